@@ hw/rtl/ttcb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ttcb_pkg: shared types and constants of the trace capture buffer
// Beat layouts, buffer geometry, item kind, phase, mode and register codes.
// ----------------------------------------------------------------------------
package ttcb_pkg;

   // Buffer geometry (depth must be a power of two)
   localparam int BUFFER_DEPTH = 1024;
   localparam int HALF_DEPTH   = BUFFER_DEPTH / 2;
   localparam int PTR_W        = $clog2(BUFFER_DEPTH);
   localparam int CNT_W        = PTR_W + 1;
   localparam int MARKER_IDS   = 128;
   localparam int ID_W         = 7;
   localparam int STAMP_W      = 64;
   localparam int ENTRY_W      = 1 + ID_W + STAMP_W;   // exit, id, stamp

   // Item kinds
   localparam logic [1:0] KIND_MARKER = 2'd0;
   localparam logic [1:0] KIND_START  = 2'd1;
   localparam logic [1:0] KIND_STOP   = 2'd2;
   localparam logic [1:0] KIND_READ   = 2'd3;

   // Capture phases
   localparam logic [1:0] PHASE_IDLE      = 2'd0;
   localparam logic [1:0] PHASE_WAITING   = 2'd1;
   localparam logic [1:0] PHASE_TRIGGERED = 2'd2;

   // Trigger modes; free run has no stop condition and ignores start beats
   localparam logic [1:0] MODE_START    = 2'd0;
   localparam logic [1:0] MODE_CENTER   = 2'd1;
   localparam logic [1:0] MODE_END      = 2'd2;
   localparam logic [1:0] MODE_FREE_RUN = 2'd3;

   // Register indexes
   localparam logic [2:0] CSR_TRIGGER_MODE = 3'd0;
   localparam logic [2:0] CSR_FILTER_LO    = 3'd1;
   localparam logic [2:0] CSR_FILTER_HI    = 3'd2;
   localparam logic [2:0] CSR_TRIG_LO      = 3'd3;
   localparam logic [2:0] CSR_TRIG_HI      = 3'd4;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] marker;
      logic        entry_exit;
      logic [63:0] timestamp;
      logic [9:0]  read_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  capture_state;
      logic [10:0] entry_count;
      logic [10:0] trigger_count;
      logic        invalid_marker_seen;
      logic        recorded;
      logic        read_valid;
      logic [6:0]  read_marker;
      logic        read_exit;
      logic [63:0] read_timestamp;
   } rsp_type;

endpackage

`default_nettype wire

@@ hw/rtl/ttcb_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ttcb_ram: generic single-port RAM
// One access per cycle, write or read; read data registered and held.
// ----------------------------------------------------------------------------
module ttcb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata <= mem[addr];
         end
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/triggered_trace_capture_buffer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// triggered_trace_capture_buffer: triggered trace capture buffer
// Records filtered marker beats into a circular buffer and stops after a
// trigger according to the trigger mode; indexed readout of stored entries.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel (valid/ready) carries marker, start, stop and read beats.
//  - rsp channel (valid/ready) returns one beat per request beat, in order,
//    with phase, counters, sticky flag, recorded bit and read data.
//  - csr port: write enable, index, 64-bit data; write only while idle.
//  - Path: an accepted request beat passes the input register, then the
//    result register with the RAM read, before its response is valid.
//  - Throughput: one beat per cycle unless rsp stalls; all state update
//    for a beat is combinational between the two registers, and the
//    single-port trace RAM sees at most one access (write or read) per beat.
//  - Reset (synchronous, active high) clears phase, pointers, counters,
//    the flag, config and valid registers. Trace RAM is not cleared;
//    only entries written since the last start are reachable by a valid read.
//  - When rsp_ready is low the result register holds, the input register
//    fills once more, and then req_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module triggered_trace_capture_buffer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ttcb_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ttcb_pkg::rsp_type      rsp_data,
   input  wire logic              csr_we,
   input  wire logic [2:0]        csr_index,
   input  wire logic [63:0]       csr_wdata
);

   import ttcb_pkg::*;

   // Configuration registers
   logic [1:0]   mode_ff;
   logic [127:0] filter_ff;
   logic [127:0] trig_mask_ff;

   // Capture state
   logic [1:0]       phase_ff,  phase_in;
   logic [PTR_W-1:0] wr_pos_ff, wr_pos_in;
   logic [PTR_W-1:0] oldest_ff, oldest_in;
   logic [CNT_W-1:0] stored_ff, stored_in;
   logic [CNT_W-1:0] post_ff,   post_in;
   logic             bad_ff,    bad_in;

   // Pipeline registers
   logic    a_valid_ff;
   req_type a_data_ff;
   logic    b_valid_ff;
   logic [1:0]       b_phase_ff;
   logic [CNT_W-1:0] b_stored_ff;
   logic [CNT_W-1:0] b_post_ff;
   logic             b_bad_ff;
   logic             b_rec_ff,   rec_in;
   logic             b_rvalid_ff, rvalid_in;

   // RAM port
   logic               ram_en;
   logic               ram_we;
   logic [PTR_W-1:0]   ram_addr;
   logic [ENTRY_W-1:0] ram_rdata;

   logic advance;
   logic id_ok;
   logic filt_hit;
   logic trig_hit;
   logic [1:0]       phase_mid;
   logic [CNT_W-1:0] post_inc;
   logic [CNT_W-1:0] rd_sum;
   logic [PTR_W-1:0] rd_addr;

   // Stage B advances when A holds a beat and the result slot frees up
   assign advance   = a_valid_ff && (!b_valid_ff || rsp_ready);
   assign req_ready = !a_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_START;
         filter_ff    <= '0;
         trig_mask_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TRIGGER_MODE: mode_ff               <= csr_wdata[1:0];
            CSR_FILTER_LO:    filter_ff[63:0]       <= csr_wdata;
            CSR_FILTER_HI:    filter_ff[127:64]     <= csr_wdata;
            CSR_TRIG_LO:      trig_mask_ff[63:0]    <= csr_wdata;
            CSR_TRIG_HI:      trig_mask_ff[127:64]  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign id_ok    = a_data_ff.marker < 16'(MARKER_IDS);
   assign filt_hit = filter_ff[a_data_ff.marker[ID_W-1:0]];
   assign trig_hit = trig_mask_ff[a_data_ff.marker[ID_W-1:0]];
   assign post_inc = (post_ff < CNT_W'(BUFFER_DEPTH)) ? post_ff + 1'b1 : post_ff;

   // Read address wraps at the buffer depth
   assign rd_sum  = CNT_W'(oldest_ff) + CNT_W'(a_data_ff.read_index);
   assign rd_addr = (rd_sum >= CNT_W'(BUFFER_DEPTH)) ?
                    PTR_W'(rd_sum - CNT_W'(BUFFER_DEPTH)) : PTR_W'(rd_sum);

   // Per-beat state update
   always_comb begin
      phase_in  = phase_ff;
      wr_pos_in = wr_pos_ff;
      oldest_in = oldest_ff;
      stored_in = stored_ff;
      post_in   = post_ff;
      bad_in    = bad_ff;
      rec_in    = 1'b0;
      rvalid_in = 1'b0;
      phase_mid = phase_ff;
      ram_en    = 1'b0;
      ram_we    = 1'b0;
      ram_addr  = wr_pos_ff;
      unique case (a_data_ff.kind)
         KIND_MARKER: begin
            if (phase_ff != PHASE_IDLE) begin
               if (!id_ok) begin
                  bad_in = 1'b1;
               end else if (filt_hit) begin
                  rec_in    = 1'b1;
                  ram_en    = advance;
                  ram_we    = 1'b1;
                  wr_pos_in = (wr_pos_ff == PTR_W'(BUFFER_DEPTH - 1)) ?
                              '0 : wr_pos_ff + 1'b1;
                  if (stored_ff < CNT_W'(BUFFER_DEPTH)) begin
                     stored_in = stored_ff + 1'b1;
                  end else begin
                     oldest_in = wr_pos_in;
                  end
                  if (phase_ff == PHASE_WAITING && trig_hit) begin
                     phase_mid = PHASE_TRIGGERED;
                  end
                  phase_in = phase_mid;
                  if (phase_mid == PHASE_TRIGGERED) begin
                     post_in = post_inc;
                     priority case (mode_ff)
                        MODE_START: begin
                           if (post_inc >= CNT_W'(BUFFER_DEPTH)) phase_in = PHASE_IDLE;
                        end
                        MODE_CENTER: begin
                           if (post_inc >= CNT_W'(HALF_DEPTH)) phase_in = PHASE_IDLE;
                        end
                        MODE_END: phase_in = PHASE_IDLE;
                        default: ;   // free-run mode: capture goes on
                     endcase
                  end
               end
            end
         end
         KIND_START: begin
            if (mode_ff != MODE_FREE_RUN) begin
               post_in   = '0;
               oldest_in = '0;
               wr_pos_in = '0;
               stored_in = '0;
               bad_in    = 1'b0;
               phase_in  = PHASE_WAITING;
            end
         end
         KIND_STOP: begin
            phase_in = PHASE_IDLE;
         end
         KIND_READ: begin
            rvalid_in = CNT_W'(a_data_ff.read_index) < stored_ff;
            ram_en    = advance;
            ram_addr  = rd_addr;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         phase_ff   <= PHASE_IDLE;
         wr_pos_ff  <= '0;
         oldest_ff  <= '0;
         stored_ff  <= '0;
         post_ff    <= '0;
         bad_ff     <= 1'b0;
      end else begin
         if (req_ready) begin
            a_valid_ff <= req_valid;
         end
         if (advance) begin
            b_valid_ff <= 1'b1;
            phase_ff   <= phase_in;
            wr_pos_ff  <= wr_pos_in;
            oldest_ff  <= oldest_in;
            stored_ff  <= stored_in;
            post_ff    <= post_in;
            bad_ff     <= bad_in;
         end else if (rsp_ready) begin
            b_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         a_data_ff <= req_data;
      end
      if (advance) begin
         b_phase_ff  <= phase_in;
         b_stored_ff <= stored_in;
         b_post_ff   <= post_in;
         b_bad_ff    <= bad_in;
         b_rec_ff    <= rec_in;
         b_rvalid_ff <= rvalid_in;
      end
   end

   // Trace RAM entry: {exit, id, stamp}; read data holds until the next read
   ttcb_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(BUFFER_DEPTH)
   ) u_trace_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata ({a_data_ff.entry_exit, a_data_ff.marker[ID_W-1:0], a_data_ff.timestamp}),
      .rdata (ram_rdata)
   );

   assign rsp_valid = b_valid_ff;

   always_comb begin
      rsp_data                     = '0;
      rsp_data.capture_state       = b_phase_ff;
      rsp_data.entry_count         = 11'(b_stored_ff);
      rsp_data.trigger_count       = 11'(b_post_ff);
      rsp_data.invalid_marker_seen = b_bad_ff;
      rsp_data.recorded            = b_rec_ff;
      rsp_data.read_valid          = b_rvalid_ff;
      if (b_rvalid_ff) begin
         rsp_data.read_exit      = ram_rdata[ENTRY_W-1];
         rsp_data.read_marker    = ram_rdata[STAMP_W +: ID_W];
         rsp_data.read_timestamp = ram_rdata[STAMP_W-1:0];
      end
   end

`ifndef SYNTHESIS
   a_stored_bound: assert property (@(posedge clock) disable iff (reset)
      stored_ff <= CNT_W'(BUFFER_DEPTH))
      else $error("stored count above buffer depth");

   a_post_bound: assert property (@(posedge clock) disable iff (reset)
      post_ff <= CNT_W'(BUFFER_DEPTH))
      else $error("post-trigger count above buffer depth");

   a_oldest_zero: assert property (@(posedge clock) disable iff (reset)
      stored_ff < CNT_W'(BUFFER_DEPTH) |-> oldest_ff == '0)
      else $error("oldest pointer moved before buffer filled");

   a_rec_or_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(b_rec_ff && b_rvalid_ff))
      else $error("beat both recorded and read");

   a_ram_one_access: assert property (@(posedge clock) disable iff (reset)
      ram_en |-> advance)
      else $error("trace RAM accessed without stage advance");
`endif

endmodule

`default_nettype wire
